/* rtl/fm_synth_event_to_register_writer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the synth event to register writer.
// Each macro checks one implication on the rising clock edge. Reset
// disables the check.
// ---------------------------------------------------------------------------
`ifndef FM_SYNTH_EVENT_TO_REGISTER_WRITER_ASSERT_SVH
`define FM_SYNTH_EVENT_TO_REGISTER_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define FMEV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmev assertion failed");
// The consequent holds in the cycle after the antecedent.
`define FMEV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmev assertion failed");
`else
`define FMEV_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FMEV_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/fmev_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmev_pkg
// Types, register addresses, the frequency number table and the small
// constant-divisor helpers that the event to register writer uses.
// ---------------------------------------------------------------------------
package fmev_pkg;

   // Shadow memory geometry: one entry per bank and register address.
   localparam int SHADOW_ENTRIES = 512;
   localparam int SHADOW_IDX_W   = $clog2(SHADOW_ENTRIES);
   localparam int NUM_CHANNELS   = 6;

   // Event kinds.
   typedef enum logic [1:0] {
      KIND_RAW      = 2'd0,
      KIND_NOTE_ON  = 2'd1,
      KIND_NOTE_OFF = 2'd2,
      KIND_PARAM    = 2'd3
   } kind_type;

   // Parameter groups, selected by the parameter number with its two low bits cleared.
   localparam logic [5:0] PGRP_DETUNE   = 6'h04;  // 0x10
   localparam logic [5:0] PGRP_MULT     = 6'h05;  // 0x14
   localparam logic [5:0] PGRP_LEVEL    = 6'h06;  // 0x18
   localparam logic [5:0] PGRP_ATTACK   = 6'h08;  // 0x20
   localparam logic [5:0] PGRP_AMEN     = 6'h09;  // 0x24
   localparam logic [5:0] PGRP_DECAY    = 6'h0A;  // 0x28
   localparam logic [5:0] PGRP_SUSTAIN  = 6'h0C;  // 0x30
   localparam logic [5:0] PGRP_RELEASE  = 6'h0D;  // 0x34
   localparam logic [5:0] PGRP_CHANNEL  = 6'h18;  // 0x60 to 0x63

   // Channel parameters, selected by the two low bits inside the channel group.
   localparam logic [1:0] PCH_FEEDBACK  = 2'd0;
   localparam logic [1:0] PCH_ALGO      = 2'd1;
   localparam logic [1:0] PCH_AMS       = 2'd2;
   localparam logic [1:0] PCH_FMS       = 2'd3;

   // Register base addresses.
   localparam logic [7:0] REG_KEY_ONOFF = 8'h28;
   localparam logic [7:0] REG_DT_MUL    = 8'h30;
   localparam logic [7:0] REG_TL        = 8'h40;
   localparam logic [7:0] REG_KS_AR     = 8'h50;
   localparam logic [7:0] REG_AM_DR     = 8'h60;
   localparam logic [7:0] REG_SL_RR     = 8'h80;
   localparam logic [7:0] REG_FNUM_LO   = 8'hA0;
   localparam logic [7:0] REG_FNUM_HI   = 8'hA4;
   localparam logic [7:0] REG_FB_ALGO   = 8'hB0;
   localparam logic [7:0] REG_PAN_MS    = 8'hB4;
   localparam logic [7:0] KEY_ON_ALL    = 8'hF0;
   localparam logic [7:0] MASK_ALL      = 8'hFF;

   // Frequency numbers for the twelve semitones of one octave.
   localparam logic [10:0] FNUM_TABLE [12] = '{
      11'd617, 11'd653, 11'd692, 11'd733, 11'd777, 11'd823,
      11'd872, 11'd924, 11'd979, 11'd1037, 11'd1099, 11'd1164
   };

   // One input event as it is held in the issue stage.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] channel;
      logic [7:0] key;
      logic [7:0] value;
      logic       raw_bank;
      logic [7:0] raw_addr;
   } evt_type;

   // One register write on its way to the shadow merge.
   typedef struct packed {
      logic       bank;
      logic [7:0] addr;
      logic [7:0] data;
      logic [7:0] mask;
      logic       last;
   } wr_op_type;

   // One finished register write at the result port.
   typedef struct packed {
      logic       bank;
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
   } rsp_wr_type;

   // Remainder of an 8-bit value by three: base-4 digits sum to the same residue.
   function automatic logic [1:0] mod3_8b(input logic [7:0] x);
      logic [3:0] s;
      logic [2:0] t;
      s = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]} + {2'b00, x[7:6]};
      t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   // Quotient of a 6-bit value by three, by a reciprocal multiply (43/128).
   function automatic logic [4:0] div3_6b(input logic [5:0] x);
      logic [11:0] p;
      p = {6'b0, x} * 12'd43;
      return p[11:7];
   endfunction

endpackage

/* rtl/fm_synth_event_to_register_writer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm_synth_event_to_register_writer
// Translates synth events into bank/address/data register writes and keeps
// a shadow copy of every register written.
// ---------------------------------------------------------------------------
// Usage:
// The req_ channel takes one event per transaction: a raw write, a note on,
// a note off or a parameter change. The rsp_ channel delivers the register
// writes that the event causes, one per transaction, with rsp_last set on
// the final write of the event. A note on gives three writes, a raw write,
// a note off and a known parameter give one, an unknown parameter none.
// The first write of an event passes the issue stage and the merge stage
// into the output register. Throughput: one register write per cycle while
// rsp_stall is low, set by the single issue stage, which takes the next
// event as it issues the final write of the one before.
// Masked parameter writes read the 512-entry shadow memory, merge and write
// back; a write to the entry being read in the same cycle is forwarded.
// Reset: after reset the shadow memory is cleared one entry a cycle, and
// req_stall stays high until that is done.
// A stalled result holds in the output register; the stall propagates back
// through the merge and issue stages to req_stall.
// ---------------------------------------------------------------------------
`include "fm_synth_event_to_register_writer_assert.svh"

module fm_synth_event_to_register_writer
   import fmev_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Event channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_channel,
   input  logic [7:0] req_key_or_param,
   input  logic [7:0] req_value,
   input  logic       req_raw_bank,
   input  logic [7:0] req_raw_addr,
   // Register write channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_bank,
   output logic [7:0] rsp_out_addr,
   output logic [7:0] rsp_out_data,
   output logic       rsp_last
);

   // Shadow memory and its registered read data.
   logic [7:0] shadow_mem [SHADOW_ENTRIES];
   logic [7:0] shadow_rd_ff;

   // Clearing pass state.
   logic                    clear_ff, clear_in;
   logic [SHADOW_IDX_W-1:0] clr_idx_ff, clr_idx_in;

   // Issue stage.
   logic       a_valid_ff, a_valid_in;
   evt_type    a_evt_ff, a_evt_in;
   logic [1:0] a_idx_ff, a_idx_in;

   // Merge stage.
   logic       b_valid_ff, b_valid_in;
   wr_op_type  b_op_ff, b_op_in;
   logic       fwd_hit_ff, fwd_hit_in;
   logic [7:0] fwd_data_ff, fwd_data_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_wr_type rsp_wr_ff, rsp_wr_in;

   // Decode signals.
   logic [1:0]  ch_r;
   logic        ch_b;
   logic [2:0]  ch;
   logic [3:0]  slot_a;
   logic [4:0]  blk;
   logic [1:0]  semi_hi;
   logic [3:0]  semi;
   logic [10:0] fnum;
   wr_op_type   a_op;
   logic [1:0]  a_cnt;
   logic        a_last;

   // Handshake signals.
   logic       rsp_free;
   logic       b_adv;
   logic       b_ready;
   logic       a_issue;
   logic       a_done;
   logic       req_take;
   logic [7:0] b_old;
   logic [7:0] b_merged;
   logic [SHADOW_IDX_W-1:0] a_rd_idx;
   logic [SHADOW_IDX_W-1:0] b_wr_idx;

   // Channel reduced modulo six: slot is the residue by three, bank follows
   // from matching the parity of the channel number.
   always_comb begin
      ch_r = mod3_8b(a_evt_ff.channel);
      ch_b = ch_r[0] ^ a_evt_ff.channel[0];
      ch   = {1'b0, ch_r} + (ch_b ? 3'd3 : 3'd0);
      slot_a = {a_evt_ff.key[1:0], 2'b00} + {2'b00, ch_r};
   end

   // Octave and semitone of the note: key / 12 and key % 12.
   always_comb begin
      blk     = div3_6b(a_evt_ff.key[7:2]);
      semi_hi = 2'(a_evt_ff.key[7:2] - 6'(3 * blk));
      semi    = {semi_hi, a_evt_ff.key[1:0]};
      fnum    = FNUM_TABLE[semi];
   end

   // Build the write for the current position inside the event.
   always_comb begin
      a_op      = '0;
      a_op.bank = ch_b;
      a_op.data = a_evt_ff.value;
      a_op.mask = MASK_ALL;
      a_cnt     = 2'd1;
      case (a_evt_ff.kind)
         KIND_RAW: begin
            a_op.bank = a_evt_ff.raw_bank;
            a_op.addr = a_evt_ff.raw_addr;
         end
         KIND_NOTE_ON: begin
            a_cnt = 2'd3;
            case (a_idx_ff)
               2'd0: begin
                  a_op.addr = REG_FNUM_HI + {6'b0, ch_r};
                  a_op.data = {blk, fnum[10:8]};
               end
               2'd1: begin
                  a_op.addr = REG_FNUM_LO + {6'b0, ch_r};
                  a_op.data = fnum[7:0];
               end
               default: begin
                  a_op.bank = 1'b0;
                  a_op.addr = REG_KEY_ONOFF;
                  a_op.data = KEY_ON_ALL | {5'b0, ch};
               end
            endcase
         end
         KIND_NOTE_OFF: begin
            a_op.bank = 1'b0;
            a_op.addr = REG_KEY_ONOFF;
            a_op.data = {5'b0, ch};
         end
         KIND_PARAM: begin
            case (a_evt_ff.key[7:2])
               PGRP_DETUNE: begin
                  a_op.addr = REG_DT_MUL + {4'b0, slot_a};
                  a_op.mask = 8'h70;
                  a_op.data = {1'b0, a_evt_ff.value[2:0], 4'b0};
               end
               PGRP_MULT: begin
                  a_op.addr = REG_DT_MUL + {4'b0, slot_a};
                  a_op.mask = 8'h0F;
               end
               PGRP_LEVEL: begin
                  a_op.addr = REG_TL + {4'b0, slot_a};
               end
               PGRP_ATTACK: begin
                  a_op.addr = REG_KS_AR + {4'b0, slot_a};
                  a_op.mask = 8'h1F;
               end
               PGRP_AMEN: begin
                  a_op.addr = REG_AM_DR + {4'b0, slot_a};
                  a_op.mask = 8'h80;
                  a_op.data = {a_evt_ff.value[0], 7'b0};
               end
               PGRP_DECAY: begin
                  a_op.addr = REG_AM_DR + {4'b0, slot_a};
                  a_op.mask = 8'h1F;
               end
               PGRP_SUSTAIN: begin
                  a_op.addr = REG_SL_RR + {4'b0, slot_a};
                  a_op.mask = 8'hF0;
                  a_op.data = {a_evt_ff.value[3:0], 4'b0};
               end
               PGRP_RELEASE: begin
                  a_op.addr = REG_SL_RR + {4'b0, slot_a};
                  a_op.mask = 8'h0F;
               end
               PGRP_CHANNEL: begin
                  case (a_evt_ff.key[1:0])
                     PCH_FEEDBACK: begin
                        a_op.addr = REG_FB_ALGO + {6'b0, ch_r};
                        a_op.mask = 8'h38;
                        a_op.data = {a_evt_ff.value[4:0], 3'b0};
                     end
                     PCH_ALGO: begin
                        a_op.addr = REG_FB_ALGO + {6'b0, ch_r};
                        a_op.mask = 8'h07;
                     end
                     PCH_AMS: begin
                        a_op.addr = REG_PAN_MS + {6'b0, ch_r};
                        a_op.mask = 8'h38;
                        a_op.data = {a_evt_ff.value[4:0], 3'b0};
                     end
                     default: begin
                        a_op.addr = REG_PAN_MS + {6'b0, ch_r};
                        a_op.mask = 8'h03;
                     end
                  endcase
               end
               default: begin
                  a_cnt = 2'd0;
               end
            endcase
         end
         default: begin
            a_cnt = 2'd0;
         end
      endcase
      a_last    = (a_idx_ff == (a_cnt - 2'd1));
      a_op.last = a_last;
   end

   // Flow control from the output back to the event channel.
   always_comb begin
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      b_adv     = b_valid_ff && rsp_free;
      b_ready   = !b_valid_ff || rsp_free;
      a_issue   = a_valid_ff && (a_cnt != 2'd0) && b_ready;
      a_done    = a_valid_ff && ((a_cnt == 2'd0) || (b_ready && a_last));
      req_stall = clear_ff || (a_valid_ff && !a_done);
      req_take  = req_valid && !req_stall;
   end

   // Merge new bits into the shadow value, taking a same-entry write forwarded.
   always_comb begin
      a_rd_idx = {a_op.bank, a_op.addr};
      b_wr_idx = {b_op_ff.bank, b_op_ff.addr};
      b_old    = fwd_hit_ff ? fwd_data_ff : shadow_rd_ff;
      b_merged = (b_old & ~b_op_ff.mask) | (b_op_ff.data & b_op_ff.mask);
   end

   // Next values of the clearing pass.
   always_comb begin
      clear_in   = clear_ff;
      clr_idx_in = clr_idx_ff;
      if (clear_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == SHADOW_IDX_W'(SHADOW_ENTRIES - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // Next values of the issue stage.
   always_comb begin
      a_valid_in = a_valid_ff;
      a_evt_in   = a_evt_ff;
      a_idx_in   = a_idx_ff;
      if (a_done) begin
         a_valid_in = 1'b0;
      end else if (a_issue) begin
         a_idx_in = a_idx_ff + 2'd1;
      end
      if (req_take) begin
         a_valid_in        = 1'b1;
         a_idx_in          = 2'd0;
         a_evt_in.kind     = kind_type'(req_kind);
         a_evt_in.channel  = req_channel;
         a_evt_in.key      = req_key_or_param;
         a_evt_in.value    = req_value;
         a_evt_in.raw_bank = req_raw_bank;
         a_evt_in.raw_addr = req_raw_addr;
      end
   end

   // Next values of the merge stage and its forwarding register.
   always_comb begin
      b_valid_in  = b_valid_ff;
      b_op_in     = b_op_ff;
      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (b_ready) begin
         b_valid_in = a_issue;
         if (a_issue) begin
            b_op_in     = a_op;
            fwd_hit_in  = b_adv && (b_wr_idx == a_rd_idx);
            fwd_data_in = b_merged;
         end
      end
   end

   // Next values of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_wr_in    = rsp_wr_ff;
      if (rsp_free) begin
         rsp_valid_in = b_valid_ff;
         if (b_valid_ff) begin
            rsp_wr_in.bank = b_op_ff.bank;
            rsp_wr_in.addr = b_op_ff.addr;
            rsp_wr_in.data = b_merged;
            rsp_wr_in.last = b_op_ff.last;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_idx_ff   <= '0;
         a_valid_ff   <= 1'b0;
         a_idx_ff     <= 2'd0;
         b_valid_ff   <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_idx_ff   <= clr_idx_in;
         a_valid_ff   <= a_valid_in;
         a_idx_ff     <= a_idx_in;
         b_valid_ff   <= b_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_evt_ff    <= a_evt_in;
      b_op_ff     <= b_op_in;
      fwd_data_ff <= fwd_data_in;
      rsp_wr_ff   <= rsp_wr_in;
   end

   // Shadow memory: one write port shared by the clearing pass and the merge,
   // one registered read port for the issue stage.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         shadow_mem[clr_idx_ff] <= 8'h00;
      end else if (b_adv) begin
         shadow_mem[b_wr_idx] <= b_merged;
      end
   end

   always_ff @(posedge clock) begin
      if (a_issue) begin
         shadow_rd_ff <= shadow_mem[a_rd_idx];
      end
   end

   // Result port.
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_bank = rsp_wr_ff.bank;
   assign rsp_out_addr = rsp_wr_ff.addr;
   assign rsp_out_data = rsp_wr_ff.data;
   assign rsp_last     = rsp_wr_ff.last;

   // The pipeline stays empty while the shadow memory is being cleared.
   `FMEV_ASSERT_IMP(a_clear_empty, clock, reset, clear_ff, !a_valid_ff && !b_valid_ff && !rsp_valid_ff)
   // Only a note on issues more than one write.
   `FMEV_ASSERT_IMP(a_multi_note_on, clock, reset, a_valid_ff && (a_idx_ff != 2'd0), (a_evt_ff.kind == KIND_NOTE_ON) && (a_idx_ff != 2'd3))
   // A freshly loaded forwarded value comes from a write that left the merge stage in the previous cycle.
   `FMEV_ASSERT_IMP(a_fwd_source, clock, reset, b_valid_ff && fwd_hit_ff && $past(a_issue), $past(b_adv))
   // The final write of an event frees the issue stage for the next event.
   `FMEV_ASSERT_NXT(a_last_frees, clock, reset, a_issue && a_last && !req_take, !a_valid_ff)

endmodule

/* bench/fm_synth_event_to_register_writer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm_synth_event_to_register_writer_tb
// Self-checking bench for the synth event to register writer. A queue of
// synth events feeds a clocked driver. An in-bench register model follows
// each accepted event and keeps its own copy of the 512-entry shadow, so it
// can predict masked read-modify-write results. A clocked monitor compares
// every register write with the oldest prediction. The driver idles and
// the receiver stalls at random, and the receiver once holds off for a
// long stretch so that back-pressure reaches the event port.
// ---------------------------------------------------------------------------
module fm_synth_event_to_register_writer_tb
   import fmev_pkg::*;
();

   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AT      = 150;
   localparam int RANDOM_BUSY  = 458;
   localparam int PRINT_LIMIT  = 40;

   // Frequency numbers per semitone, kept separate from the design's table.
   localparam logic [10:0] SEMITONE_FNUM [12] = '{
      11'd617, 11'd653, 11'd692, 11'd733, 11'd777, 11'd823,
      11'd872, 11'd924, 11'd979, 11'd1037, 11'd1099, 11'd1164
   };

   // Parameter groups that produce a write.
   localparam logic [5:0] KNOWN_GROUPS [9] = '{
      PGRP_DETUNE, PGRP_MULT, PGRP_LEVEL, PGRP_ATTACK, PGRP_AMEN,
      PGRP_DECAY, PGRP_SUSTAIN, PGRP_RELEASE, PGRP_CHANNEL
   };

   // Register bases where raw writes collide with masked parameter writes.
   localparam logic [7:0] RMW_BASES [7] = '{
      REG_DT_MUL, REG_TL, REG_KS_AR, REG_AM_DR, REG_SL_RR, REG_FB_ALGO, REG_PAN_MS
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = KIND_RAW;
   logic [7:0] req_channel = 8'h00;
   logic [7:0] req_key_or_param = 8'h00;
   logic [7:0] req_value = 8'h00;
   logic       req_raw_bank = 1'b0;
   logic [7:0] req_raw_addr = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_out_bank;
   logic [7:0] rsp_out_addr;
   logic [7:0] rsp_out_data;
   logic       rsp_last;

   evt_type    event_backlog [$];
   rsp_wr_type reg_writes_due [$];
   logic [7:0] shadow_image [SHADOW_ENTRIES];
   evt_type    offered;
   int         events_taken = 0;
   int         kind_count [4] = '{0, 0, 0, 0};
   int         writes_seen = 0;
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         hold_left = 0;
   logic       hold_done = 1'b0;

   fm_synth_event_to_register_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_channel      (req_channel),
      .req_key_or_param (req_key_or_param),
      .req_value        (req_value),
      .req_raw_bank     (req_raw_bank),
      .req_raw_addr     (req_raw_addr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_bank     (rsp_out_bank),
      .rsp_out_addr     (rsp_out_addr),
      .rsp_out_data     (rsp_out_data),
      .rsp_last         (rsp_last)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Merges one write into the shadow copy and queues it as an expected result.
   function automatic void shadow_merge(input logic bank, input logic [7:0] addr,
                                        input logic [7:0] data, input logic [7:0] mask);
      logic [7:0] merged;
      merged = (shadow_image[{bank, addr}] & ~mask) | (data & mask);
      shadow_image[{bank, addr}] = merged;
      reg_writes_due.push_back('{bank: bank, addr: addr, data: merged, last: 1'b0});
   endfunction

   // Works out the register writes that one accepted event causes.
   function automatic void predict_writes(input evt_type e);
      logic [7:0]  ch;
      logic        b;
      logic [1:0]  r;
      logic [7:0]  slot;
      logic [7:0]  blk;
      logic [10:0] f;
      int          queued;
      queued = reg_writes_due.size();
      ch = e.channel % 8'd6;
      b = (ch >= 8'd3);
      r = 2'(ch % 8'd3);
      slot = {4'd0, e.key[1:0], 2'b00} + {6'd0, r};
      case (e.kind)
         KIND_RAW: shadow_merge(e.raw_bank, e.raw_addr, e.value, MASK_ALL);
         KIND_NOTE_ON: begin
            f = SEMITONE_FNUM[e.key % 8'd12];
            blk = e.key / 8'd12;
            shadow_merge(b, REG_FNUM_HI + r, (blk << 3) | {5'd0, f[10:8]}, MASK_ALL);
            shadow_merge(b, REG_FNUM_LO + r, f[7:0], MASK_ALL);
            shadow_merge(1'b0, REG_KEY_ONOFF, KEY_ON_ALL | ch, MASK_ALL);
         end
         KIND_NOTE_OFF: shadow_merge(1'b0, REG_KEY_ONOFF, ch, MASK_ALL);
         KIND_PARAM: begin
            case (e.key[7:2])
               PGRP_DETUNE:  shadow_merge(b, REG_DT_MUL + slot, e.value << 4, 8'h70);
               PGRP_MULT:    shadow_merge(b, REG_DT_MUL + slot, e.value, 8'h0F);
               PGRP_LEVEL:   shadow_merge(b, REG_TL + slot, e.value, MASK_ALL);
               PGRP_ATTACK:  shadow_merge(b, REG_KS_AR + slot, e.value, 8'h1F);
               PGRP_AMEN:    shadow_merge(b, REG_AM_DR + slot, e.value << 7, 8'h80);
               PGRP_DECAY:   shadow_merge(b, REG_AM_DR + slot, e.value, 8'h1F);
               PGRP_SUSTAIN: shadow_merge(b, REG_SL_RR + slot, e.value << 4, 8'hF0);
               PGRP_RELEASE: shadow_merge(b, REG_SL_RR + slot, e.value, 8'h0F);
               PGRP_CHANNEL: begin
                  case (e.key[1:0])
                     PCH_FEEDBACK: shadow_merge(b, REG_FB_ALGO + r, e.value << 3, 8'h38);
                     PCH_ALGO:     shadow_merge(b, REG_FB_ALGO + r, e.value, 8'h07);
                     PCH_AMS:      shadow_merge(b, REG_PAN_MS + r, e.value << 3, 8'h38);
                     PCH_FMS:      shadow_merge(b, REG_PAN_MS + r, e.value, 8'h03);
                     default: ;
                  endcase
               end
               // Unknown parameter numbers write nothing.
               default: ;
            endcase
         end
         default: ;
      endcase
      if (reg_writes_due.size() > queued) begin
         reg_writes_due[reg_writes_due.size() - 1].last = 1'b1;
      end
   endfunction

   // True when an event leads to at least one register write.
   function automatic bit causes_write(input evt_type e);
      return e.kind != KIND_PARAM || e.key[7:2] inside {PGRP_DETUNE, PGRP_MULT,
         PGRP_LEVEL, PGRP_ATTACK, PGRP_AMEN, PGRP_DECAY, PGRP_SUSTAIN, PGRP_RELEASE,
         PGRP_CHANNEL};
   endfunction

   // Mostly well-formed events with random content, plus some noise.
   function automatic evt_type random_event();
      evt_type e;
      int      pick;
      e.channel = 8'($urandom_range(0, 255));
      e.key = 8'($urandom_range(0, 255));
      e.value = 8'($urandom_range(0, 255));
      e.raw_bank = 1'($urandom_range(0, 1));
      e.raw_addr = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         e.kind = KIND_RAW;
         if ($urandom_range(0, 1) == 0) begin
            e.raw_addr = RMW_BASES[$urandom_range(0, 6)] + 8'($urandom_range(0, 15));
         end
      end else if (pick < 45) begin
         e.kind = KIND_NOTE_ON;
      end else if (pick < 58) begin
         e.kind = KIND_NOTE_OFF;
      end else begin
         e.kind = KIND_PARAM;
         if ($urandom_range(0, 9) != 0) begin
            e.key = {KNOWN_GROUPS[$urandom_range(0, 8)], 2'($urandom_range(0, 3))};
         end
      end
      return e;
   endfunction

   task automatic queue_event(input kind_type k, input logic [7:0] ch, input logic [7:0] key,
                              input logic [7:0] val, input logic rb, input logic [7:0] ra);
      event_backlog.push_back('{kind: k, channel: ch, key: key, value: val,
                                raw_bank: rb, raw_addr: ra});
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   // Event driver: offers the next queued event, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_writes(offered);
            kind_count[offered.kind]++;
            events_taken++;
         end
         if (event_backlog.size() != 0 &&
             ((events_taken >= 250 && events_taken < 330) || $urandom_range(0, 99) >= 31)) begin
            offered = event_backlog.pop_front();
            req_kind <= offered.kind;
            req_channel <= offered.channel;
            req_key_or_param <= offered.key;
            req_value <= offered.value;
            req_raw_bank <= offered.raw_bank;
            req_raw_addr <= offered.raw_addr;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Write receiver: random stalls, one long hold-off and one calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && writes_seen >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (writes_seen >= 300 && writes_seen < 450) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 31);
      end
   end

   // Write monitor: each accepted write is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_wr_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         writes_seen <= writes_seen + 1;
         if (reg_writes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected write bank %0b addr %h data %h",
                                      rsp_out_bank, rsp_out_addr, rsp_out_data));
         end else begin
            want = reg_writes_due.pop_front();
            if (rsp_out_bank !== want.bank) begin
               report_mismatch($sformatf("write %0d bank: got %0b, want %0b",
                                         writes_seen, rsp_out_bank, want.bank));
            end
            if (rsp_out_addr !== want.addr) begin
               report_mismatch($sformatf("write %0d addr: got %h, want %h",
                                         writes_seen, rsp_out_addr, want.addr));
            end
            if (rsp_out_data !== want.data) begin
               report_mismatch($sformatf("write %0d data at %h: got %h, want %h",
                                         writes_seen, want.addr, rsp_out_data, want.data));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("write %0d last: got %0b, want %0b",
                                         writes_seen, rsp_last, want.last));
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      evt_type e;
      int      busy_items;
      busy_items = 0;
      foreach (shadow_image[i]) begin
         shadow_image[i] = 8'h00;
      end

      // Raw writes at the field extremes, and a seed for a masked merge.
      queue_event(KIND_RAW, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
      queue_event(KIND_RAW, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      queue_event(KIND_RAW, 8'h01, 8'h00, 8'hA5, 1'b0, 8'h31);
      queue_event(KIND_PARAM, 8'h01, 8'h10, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h01, 8'h14, 8'h03, 1'b1, 8'hFF);
      // Note on at the lowest note, and at the top note with the largest block.
      queue_event(KIND_NOTE_ON, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
      queue_event(KIND_NOTE_ON, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      queue_event(KIND_NOTE_ON, 8'h05, 8'h7F, 8'h55, 1'b0, 8'hAA);
      queue_event(KIND_NOTE_OFF, 8'h05, 8'h00, 8'h00, 1'b0, 8'h00);
      queue_event(KIND_NOTE_OFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      // The remaining operator groups and every channel parameter.
      queue_event(KIND_PARAM, 8'h02, 8'h18, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h04, 8'h21, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h03, 8'h26, 8'h01, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h00, 8'h2B, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h01, 8'h30, 8'h0F, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h02, 8'h37, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h00, 8'h60, 8'h07, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h00, 8'h61, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h04, 8'h62, 8'h05, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'h05, 8'h63, 8'hFF, 1'b0, 8'h00);
      // Unknown parameter numbers give no write.
      queue_event(KIND_PARAM, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00);
      queue_event(KIND_PARAM, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      queue_event(KIND_PARAM, 8'h03, 8'h64, 8'h12, 1'b0, 8'h00);

      // Random events; ignored ones do not count toward the total.
      while (busy_items < RANDOM_BUSY) begin
         e = random_event();
         event_backlog.push_back(e);
         if (causes_write(e)) begin
            busy_items++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: all events taken, all writes seen, then a short settle.
      while (event_backlog.size() != 0 || req_valid) @(negedge clock);
      while (reg_writes_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("%0d events (raw %0d, note on %0d, note off %0d, parameter %0d), %0d writes",
               events_taken, kind_count[KIND_RAW], kind_count[KIND_NOTE_ON],
               kind_count[KIND_NOTE_OFF], kind_count[KIND_PARAM], writes_seen);
      $display("shadow merges on all groups, random stalls and a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* fm_synth_event_to_register_writer.f */
+incdir+rtl
rtl/fmev_pkg.sv
rtl/fm_synth_event_to_register_writer.sv
bench/fm_synth_event_to_register_writer_tb.sv
